// ===== rtl/core/wpsc_pkg.sv =====
// Package for the waypoint PI steering controller: field widths, phase and
// event codes, register indexes and the CORDIC arctangent table.
// Used by the controller core and its port checker.
`timescale 1ns / 1ps

package wpsc_pkg;

    // Controller phase codes.
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_DRIVE = 2'd1,
        PH_TURN  = 2'd2
    } phase_t;

    // Event codes carried on the result tuser.
    localparam logic [1:0] EV_RUN  = 2'd0;
    localparam logic [1:0] EV_POS  = 2'd1;
    localparam logic [1:0] EV_HEAD = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_KP_LIN  = 3'd0;
    localparam logic [2:0] REG_KP_ANG  = 3'd1;
    localparam logic [2:0] REG_KI_ANG  = 3'd2;
    localparam logic [2:0] REG_LIN_LIM = 3'd3;
    localparam logic [2:0] REG_ROT_LIM = 3'd4;
    localparam logic [2:0] REG_INT_LIM = 3'd5;
    localparam logic [2:0] REG_DIST_TH = 3'd6;
    localparam logic [2:0] REG_ANG_TH  = 3'd7;

    // Packed widths of the stream payloads.
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 24;

    // Pi in units of 2^-16 mrad.
    localparam logic signed [30:0] PI_Q16 = 31'sd205887416;

    // Number of square root digit steps for a 34-bit radicand.
    localparam int SQRT_STEPS = 17;

    // Arctangent of 2^-i in units of 2^-16 mrad.
    function automatic logic [26:0] atan_entry(input logic [4:0] idx);
        logic [26:0] v;
        case (idx)
            5'd0:  v = 27'd51471854;
            5'd1:  v = 27'd30385610;
            5'd2:  v = 27'd16054922;
            5'd3:  v = 27'd8149729;
            5'd4:  v = 27'd4090679;
            5'd5:  v = 27'd2047334;
            5'd6:  v = 27'd1023917;
            5'd7:  v = 27'd511990;
            5'd8:  v = 27'd255999;
            5'd9:  v = 27'd128000;
            5'd10: v = 27'd64000;
            5'd11: v = 27'd32000;
            5'd12: v = 27'd16000;
            5'd13: v = 27'd8000;
            5'd14: v = 27'd4000;
            5'd15: v = 27'd2000;
            5'd16: v = 27'd1000;
            5'd17: v = 27'd500;
            5'd18: v = 27'd250;
            5'd19: v = 27'd125;
            5'd20: v = 27'd62;
            5'd21: v = 27'd31;
            5'd22: v = 27'd16;
            5'd23: v = 27'd8;
            default: v = 27'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/waypoint_pi_steering_controller_unit.sv =====
// Waypoint PI steering controller: iterative CORDIC bearing, digit-serial
// square root and a shared 18x18 multiplier under one sequencer.
// Depends on wpsc_pkg.
`timescale 1ns / 1ps
//
// Usage. One request on the s_ channel is one control tick: the pose and the
// target waypoint in tdata, the start flag in tuser. The block answers with
// zero, one or two results on the m_ channel (speeds in tdata, phase event in
// tuser, tlast on the last result of the tick). A start request enters the
// drive phase with the integrator cleared. A tick while idle and without the
// start flag gives no result.
// A drive tick runs the CORDIC iterations and the 17 square root digit steps
// side by side before its first result; a turn tick goes straight to the
// gain products.
// Squares and gain products pass through one shared multiplier, one
// product per cycle. The block takes one request at a time: s_tready is high
// only while the sequencer is idle, so the next request waits until every
// result of the tick has been taken.
// A stalled receiver holds the result in its register until m_tready.
// Configuration writes on the cfg_ channel are always taken; cfg_ready is tied high.
// Reset (aresetn low, synchronous) restores the register defaults, the idle
// phase and a zero integrator.

module waypoint_pi_steering_controller_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Tick request. tdata from bit 0: pose_x(16), pose_y(16), pose_heading(13),
    // target_x(16), target_y(16), target_yaw(13), zero fill(6).
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic [0:0]  s_tuser,       // start_req
    // Results. tdata from bit 0: linear_speed(10), angular_speed(13), zero(1).
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic [1:0]  m_tuser,       // phase_event
    output logic        m_tlast,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    localparam int ITER_N = (CORDIC_STEPS > wpsc_pkg::SQRT_STEPS) ?
                            CORDIC_STEPS : wpsc_pkg::SQRT_STEPS;
    localparam int CW = $clog2(ITER_N);

    typedef enum logic [3:0] {
        S_IDLE, S_SQX, S_SQY, S_SUM, S_ITER, S_FIN, S_KI, S_KP, S_LIN, S_LOUT,
        S_OUT0, S_OUT1
    } state_t;

    state_t state_reg;
    wpsc_pkg::phase_t phase_reg;

    // Configuration registers.
    logic [11:0] kp_lin_reg, kp_ang_reg, ki_ang_reg, rot_lim_reg, int_lim_reg;
    logic [11:0] ang_th_reg;
    logic [9:0]  lin_lim_reg, dist_th_reg;

    // Datapath registers.
    logic signed [16:0] dx_reg, dy_reg;
    logic signed [27:0] x_reg, y_reg;
    logic signed [30:0] z_reg;
    logic               zero_reg;
    logic [33:0]        rad_reg;
    logic [18:0]        rem_reg;
    logic [16:0]        root_reg;
    logic [CW-1:0]      cnt_reg;
    logic signed [15:0] err_reg;
    logic signed [12:0] integ_reg;
    logic signed [12:0] ang_reg;
    logic               done_reg;
    logic signed [35:0] mul_reg;

    // Input field views.
    logic signed [15:0] in_px, in_py, in_tx, in_ty;
    logic signed [12:0] in_ph, in_tyaw;
    assign in_px   = s_tdata[15:0];
    assign in_py   = s_tdata[31:16];
    assign in_ph   = s_tdata[44:32];
    assign in_tx   = s_tdata[60:45];
    assign in_ty   = s_tdata[76:61];
    assign in_tyaw = s_tdata[89:77];

    logic signed [12:0] ph_reg;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // Request decode: start flag, then phase, decides the path.
    logic               start;
    logic signed [16:0] dx_in, dy_in;
    logic signed [27:0] x_in, y_in;
    logic signed [15:0] turn_err_raw, turn_err;
    assign start = s_tuser[0];
    assign dx_in = 17'(in_tx) - 17'(in_px);
    assign dy_in = 17'(in_ty) - 17'(in_py);
    assign x_in  = {{3{dx_in[16]}}, dx_in, 8'd0};
    assign y_in  = {{3{dy_in[16]}}, dy_in, 8'd0};
    assign turn_err_raw = 16'(in_tyaw) - 16'(in_ph);

    function automatic logic signed [15:0] wrap(input logic signed [15:0] e);
        logic signed [15:0] r;
        if (e > 16'sd3141)       r = e - 16'sd6283;
        else if (e < -16'sd3141) r = e + 16'sd6283;
        else                     r = e;
        return r;
    endfunction

    assign turn_err = wrap(turn_err_raw);

    // Shared multiplier operand select.
    logic signed [17:0] mul_a, mul_b;
    always_comb begin
        case (state_reg)
            S_SQX: begin
                mul_a = 18'(dx_reg);
                mul_b = 18'(dx_reg);
            end
            S_SQY: begin
                mul_a = 18'(dy_reg);
                mul_b = 18'(dy_reg);
            end
            S_KI: begin
                mul_a = $signed({6'd0, ki_ang_reg});
                mul_b = 18'(err_reg);
            end
            S_KP: begin
                mul_a = $signed({6'd0, kp_ang_reg});
                mul_b = 18'(err_reg);
            end
            S_LIN: begin
                mul_a = $signed({6'd0, kp_lin_reg});
                mul_b = $signed({1'b0, root_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // One CORDIC vectoring step.
    logic signed [27:0] xs, ys, x_next, y_next;
    logic signed [30:0] z_next, atan_v;
    assign xs     = x_reg >>> cnt_reg;
    assign ys     = y_reg >>> cnt_reg;
    assign atan_v = $signed({4'd0, wpsc_pkg::atan_entry(cnt_reg[4:0])});
    always_comb begin
        if (y_reg > 28'sd0) begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + atan_v;
        end else begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - atan_v;
        end
    end

    // One square root digit step.
    logic [20:0] rem_sh, trial;
    logic [18:0] rem_next;
    logic [16:0] root_next;
    assign rem_sh = {rem_reg, rad_reg[33:32]};
    assign trial  = {2'd0, root_reg, 2'b01};
    always_comb begin
        if (rem_sh >= trial) begin
            rem_next  = 19'(rem_sh - trial);
            root_next = {root_reg[15:0], 1'b1};
        end else begin
            rem_next  = rem_sh[18:0];
            root_next = {root_reg[15:0], 1'b0};
        end
    end

    // Bearing rounded to mrad and the heading error.
    logic signed [30:0] z_round;
    logic signed [15:0] bear, drive_err;
    assign z_round   = z_reg + 31'sd32768;
    assign bear      = zero_reg ? 16'sd0 : 16'($signed(z_round[30:16]));
    assign drive_err = wrap(bear - 16'(ph_reg));

    // Integrator and angular command with clamps.
    logic signed [28:0] integ_sum, ang_sum, int_lim_s, rot_lim_s;
    logic signed [12:0] integ_next, ang_next;
    assign int_lim_s = $signed({17'd0, int_lim_reg});
    assign rot_lim_s = $signed({17'd0, rot_lim_reg});
    assign integ_sum = 29'($signed(mul_reg[35:8])) + 29'(integ_reg);
    assign ang_sum   = 29'($signed(mul_reg[35:8])) + 29'(integ_reg);
    always_comb begin
        if (integ_sum > int_lim_s)       integ_next = 13'(int_lim_s);
        else if (integ_sum < -int_lim_s) integ_next = 13'(-int_lim_s);
        else                             integ_next = 13'(integ_sum);
        if (ang_sum > rot_lim_s)         ang_next = 13'(rot_lim_s);
        else if (ang_sum < -rot_lim_s)   ang_next = 13'(-rot_lim_s);
        else                             ang_next = 13'(ang_sum);
    end

    // Linear command clamp and turn arrival test.
    logic [9:0]         lin_next;
    logic signed [15:0] err_mag;
    assign lin_next = (mul_reg[35:8] > 28'(lin_lim_reg)) ? lin_lim_reg :
                      10'(mul_reg[35:8]);
    assign err_mag  = (err_reg < 16'sd0) ? -err_reg : err_reg;

    // Sequencer, state and registered outputs.
    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= wpsc_pkg::PH_IDLE;
            integ_reg   <= '0;
            m_tvalid    <= 1'b0;
            kp_lin_reg  <= 12'd192;
            kp_ang_reg  <= 12'd256;
            ki_ang_reg  <= 12'd13;
            lin_lim_reg <= 10'd200;
            rot_lim_reg <= 12'd300;
            int_lim_reg <= 12'd100;
            dist_th_reg <= 10'd10;
            ang_th_reg  <= 12'd17;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    wpsc_pkg::REG_KP_LIN:  kp_lin_reg  <= cfg_data;
                    wpsc_pkg::REG_KP_ANG:  kp_ang_reg  <= cfg_data;
                    wpsc_pkg::REG_KI_ANG:  ki_ang_reg  <= cfg_data;
                    wpsc_pkg::REG_LIN_LIM: lin_lim_reg <= cfg_data[9:0];
                    wpsc_pkg::REG_ROT_LIM: rot_lim_reg <= cfg_data;
                    wpsc_pkg::REG_INT_LIM: int_lim_reg <= cfg_data;
                    wpsc_pkg::REG_DIST_TH: dist_th_reg <= cfg_data[9:0];
                    wpsc_pkg::REG_ANG_TH:  ang_th_reg  <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        dx_reg   <= dx_in;
                        dy_reg   <= dy_in;
                        ph_reg   <= in_ph;
                        zero_reg <= (dx_in == 17'sd0) && (dy_in == 17'sd0);
                        err_reg  <= turn_err;
                        if (x_in < 28'sd0) begin
                            x_reg <= -x_in;
                            y_reg <= -y_in;
                            z_reg <= (y_in >= 28'sd0) ? wpsc_pkg::PI_Q16 :
                                     -wpsc_pkg::PI_Q16;
                        end else begin
                            x_reg <= x_in;
                            y_reg <= y_in;
                            z_reg <= '0;
                        end
                        if (start) begin
                            phase_reg <= wpsc_pkg::PH_DRIVE;
                            integ_reg <= '0;
                            state_reg <= S_SQX;
                        end else if (phase_reg == wpsc_pkg::PH_DRIVE) begin
                            state_reg <= S_SQX;
                        end else if (phase_reg == wpsc_pkg::PH_TURN) begin
                            state_reg <= S_KI;
                        end
                    end
                end
                S_SQX: state_reg <= S_SQY;
                S_SQY: begin
                    rad_reg   <= mul_reg[33:0];
                    state_reg <= S_SUM;
                end
                S_SUM: begin
                    rad_reg   <= rad_reg + mul_reg[33:0];
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_ITER;
                end
                S_ITER: begin
                    if (32'(cnt_reg) < CORDIC_STEPS) begin
                        x_reg <= x_next;
                        y_reg <= y_next;
                        z_reg <= z_next;
                    end
                    if (32'(cnt_reg) < wpsc_pkg::SQRT_STEPS) begin
                        rem_reg  <= rem_next;
                        root_reg <= root_next;
                        rad_reg  <= {rad_reg[31:0], 2'b00};
                    end
                    if (32'(cnt_reg) == ITER_N - 1) state_reg <= S_FIN;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_FIN: begin
                    err_reg   <= drive_err;
                    state_reg <= S_KI;
                end
                S_KI: begin
                    if (phase_reg == wpsc_pkg::PH_DRIVE) begin
                        done_reg <= (root_reg <= 17'(dist_th_reg));
                    end else begin
                        done_reg <= (err_mag <= 16'(ang_th_reg));
                    end
                    state_reg <= S_KP;
                end
                S_KP: begin
                    integ_reg <= integ_next;
                    state_reg <= S_LIN;
                end
                S_LIN: begin
                    ang_reg   <= ang_next;
                    state_reg <= S_LOUT;
                end
                S_LOUT: begin
                    m_tdata   <= {1'b0, ang_reg,
                                  (phase_reg == wpsc_pkg::PH_DRIVE) ? lin_next : 10'd0};
                    m_tuser   <= wpsc_pkg::EV_RUN;
                    m_tlast   <= !done_reg;
                    m_tvalid  <= 1'b1;
                    state_reg <= S_OUT0;
                end
                S_OUT0: begin
                    if (m_tready) begin
                        if (done_reg) begin
                            if (phase_reg == wpsc_pkg::PH_DRIVE) begin
                                m_tdata   <= '0;
                                m_tuser   <= wpsc_pkg::EV_POS;
                                phase_reg <= wpsc_pkg::PH_TURN;
                                integ_reg <= '0;
                            end else begin
                                m_tdata   <= {14'd0, lin_lim_reg};
                                m_tuser   <= wpsc_pkg::EV_HEAD;
                                phase_reg <= wpsc_pkg::PH_IDLE;
                            end
                            m_tlast   <= 1'b1;
                            state_reg <= S_OUT1;
                        end else begin
                            m_tvalid  <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_OUT1: begin
                    if (m_tready) begin
                        m_tvalid  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/wpsc_checker.sv =====
// Port checker for the waypoint PI steering controller, bound to the top
// level. Depends on wpsc_pkg for the event codes.
`timescale 1ns / 1ps

module wpsc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // A result held back by the receiver keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // No new request is taken while a result is pending.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("request taken while result pending");

    // Arrival events always close the tick.
    a_evlast: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != wpsc_pkg::EV_RUN |-> m_tlast)
        else $error("arrival event without tlast");

    // Event code stays within the defined set.
    a_evcode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("undefined event code");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

endmodule

bind waypoint_pi_steering_controller_unit wpsc_checker u_wpsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/sv/tb_waypoint_pi_steering_controller_unit.sv =====
// Testbench for the waypoint PI steering controller: random and directed ticks
// checked against a behavioral predictor of the controller.
// Depends on wpsc_pkg and waypoint_pi_steering_controller_unit.
`timescale 1ns / 1ps

module tb_waypoint_pi_steering_controller_unit;

    localparam int STEPS = 16;

    typedef struct packed {
        logic               start;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [12:0] ph;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic signed [12:0] tyaw;
    } tick_t;

    typedef struct packed {
        logic [9:0]         lin;
        logic signed [12:0] ang;
        logic [1:0]         ev;
        logic               last;
    } cmd_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [11:0] cfg_data = '0;

    waypoint_pi_steering_controller_unit #(.CORDIC_STEPS(STEPS)) dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Predictor copy of the registers and state.
    longint gain[8];
    wpsc_pkg::phase_t ctl_phase;
    longint integ;

    tick_t pending_ticks[$];
    cmd_t  expected_cmds[$];
    tick_t cur_tick;        // request currently on the s_ channel
    int    errors = 0;
    bit    calm = 1'b0;     // no idling in the final stretch
    int    s_gap = 0, m_gap = 0;

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r = 0;
        longint b = longint'(1) << 40;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // CORDIC vectoring bearing in mrad, rounded half up.
    function automatic longint bearing_mrad(longint dx, longint dy);
        longint x = dx * 256;
        longint y = dy * 256;
        longint z = 0;
        longint xs, ys;
        if (dx == 0 && dy == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? longint'(wpsc_pkg::PI_Q16) : -longint'(wpsc_pkg::PI_Q16);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (y > 0) begin
                x += ys; y -= xs; z += longint'(wpsc_pkg::atan_entry(5'(i)));
            end else begin
                x -= ys; y += xs; z -= longint'(wpsc_pkg::atan_entry(5'(i)));
            end
        end
        return asr(z + 32768, 16);
    endfunction

    function automatic longint wrap_err(longint e);
        if (e > 3141) return e - 6283;
        if (e < -3141) return e + 6283;
        return e;
    endfunction

    function automatic longint steer(longint err);
        integ = clip(integ + asr(gain[wpsc_pkg::REG_KI_ANG] * err, 8),
                     gain[wpsc_pkg::REG_INT_LIM]);
        return clip(asr(gain[wpsc_pkg::REG_KP_ANG] * err, 8) + integ,
                    gain[wpsc_pkg::REG_ROT_LIM]);
    endfunction

    function automatic void push_cmd(longint lin, longint ang, logic [1:0] ev, logic last);
        cmd_t c;
        c.lin = 10'(lin);
        c.ang = 13'(ang);
        c.ev = ev;
        c.last = last;
        expected_cmds.push_back(c);
    endfunction

    // Work out the commands that one tick causes.
    function automatic void predict_tick(tick_t t);
        longint dx, dy, dist_mm, ang, lin, err, mag;
        if (t.start) begin
            ctl_phase = wpsc_pkg::PH_DRIVE;
            integ = 0;
        end
        if (ctl_phase == wpsc_pkg::PH_DRIVE) begin
            dx = longint'(t.tx) - longint'(t.px);
            dy = longint'(t.ty) - longint'(t.py);
            dist_mm = int_sqrt(dx * dx + dy * dy);
            ang = steer(wrap_err(bearing_mrad(dx, dy) - longint'(t.ph)));
            lin = (dist_mm * gain[wpsc_pkg::REG_KP_LIN]) >> 8;
            if (lin > gain[wpsc_pkg::REG_LIN_LIM]) lin = gain[wpsc_pkg::REG_LIN_LIM];
            if (dist_mm <= gain[wpsc_pkg::REG_DIST_TH]) begin
                push_cmd(lin, ang, wpsc_pkg::EV_RUN, 1'b0);
                push_cmd(0, 0, wpsc_pkg::EV_POS, 1'b1);
                ctl_phase = wpsc_pkg::PH_TURN;
                integ = 0;
            end else begin
                push_cmd(lin, ang, wpsc_pkg::EV_RUN, 1'b1);
            end
        end else if (ctl_phase == wpsc_pkg::PH_TURN) begin
            err = wrap_err(longint'(t.tyaw) - longint'(t.ph));
            ang = steer(err);
            mag = err < 0 ? -err : err;
            if (mag <= gain[wpsc_pkg::REG_ANG_TH]) begin
                push_cmd(0, ang, wpsc_pkg::EV_RUN, 1'b0);
                push_cmd(gain[wpsc_pkg::REG_LIN_LIM], 0, wpsc_pkg::EV_HEAD, 1'b1);
                ctl_phase = wpsc_pkg::PH_IDLE;
            end else begin
                push_cmd(0, ang, wpsc_pkg::EV_RUN, 1'b1);
            end
        end
    endfunction

    // Request driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) predict_tick(cur_tick);
            if (s_gap > 0) begin
                s_gap <= s_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_ticks.size() > 0) begin
                tick_t t;
                t = pending_ticks.pop_front();
                cur_tick <= t;
                s_tvalid <= 1'b1;
                s_tuser <= t.start;
                s_tdata <= {6'b0, t.tyaw, t.ty, t.tx, t.ph, t.py, t.px};
                if (!calm && $urandom_range(0, 7) == 0) s_gap <= $urandom_range(1, 12);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                cmd_t e;
                if (expected_cmds.size() == 0) begin
                    $error("unexpected result lin=%0d ang=%0d", m_tdata[9:0],
                           $signed(m_tdata[22:10]));
                    errors++;
                end else begin
                    e = expected_cmds.pop_front();
                    if (m_tdata[9:0] !== e.lin) begin
                        $error("linear_speed exp %0d got %0d", e.lin, m_tdata[9:0]);
                        errors++;
                    end
                    if ($signed(m_tdata[22:10]) !== e.ang) begin
                        $error("angular_speed exp %0d got %0d", e.ang,
                               $signed(m_tdata[22:10]));
                        errors++;
                    end
                    if (m_tuser !== e.ev) begin
                        $error("phase_event exp %0d got %0d", e.ev, m_tuser);
                        errors++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last exp %0d got %0d", e.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0) m_gap <= $urandom_range(1, 12);
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, int val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 12'(val);
        do @(posedge aclk); while (!cfg_ready);
        gain[idx] = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_ticks.size() > 0 || s_tvalid || expected_cmds.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic tick_t mk(logic st, int px, int py, int ph, int tx, int ty, int tyaw);
        tick_t t;
        t.start = st; t.px = 16'(px); t.py = 16'(py); t.ph = 13'(ph);
        t.tx = 16'(tx); t.ty = 16'(ty); t.tyaw = 13'(tyaw);
        return t;
    endfunction

    function automatic int rnd_head();
        return $urandom_range(0, 6284) - 3142;
    endfunction

    // One waypoint run: start, approach in steps, arrive, turn, finish.
    function automatic void add_episode(int reach);
        int tx = $urandom_range(0, 65535) - 32768;
        int ty = $urandom_range(0, 65535) - 32768;
        int tyaw = rnd_head();
        int px = tx + $urandom_range(0, 2 * reach) - reach;
        int py = ty + $urandom_range(0, 2 * reach) - reach;
        int n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            pending_ticks.push_back(mk(i == 0, px, py, rnd_head(), tx, ty, tyaw));
            px = (px + tx) / 2;
            py = (py + ty) / 2;
        end
        pending_ticks.push_back(mk($urandom_range(0, 15) == 0, tx, ty, rnd_head(), tx, ty,
                                   tyaw));
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
            pending_ticks.push_back(mk(1'b0, tx, ty,
                (i == n - 1) ? tyaw + $urandom_range(0, 30) - 15 : rnd_head(), tx, ty, tyaw));
        if ($urandom_range(0, 3) == 0)
            pending_ticks.push_back(mk(1'b0, $urandom, $urandom, rnd_head(), $urandom,
                                       $urandom, rnd_head()));
    endfunction

    initial begin
        int defaults[8] = '{192, 256, 13, 200, 300, 100, 10, 17};
        int maxes[8] = '{4095, 4095, 4095, 1000, 3142, 3142, 1000, 3142};
        for (int i = 0; i < 8; i++) gain[i] = defaults[i];
        ctl_phase = wpsc_pkg::PH_IDLE;
        integ = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: idle tick, extremes, pose on target, heading wrap, turn.
        pending_ticks.push_back(mk(1'b0, 5, 5, 0, 100, 100, 0));
        pending_ticks.push_back(mk(1'b1, -32768, -32768, -3142, 32767, 32767, 3142));
        pending_ticks.push_back(mk(1'b1, 32767, 32767, 3142, -32768, -32768, -3142));
        pending_ticks.push_back(mk(1'b1, 32767, -32768, 0, -32768, 32767, 0));
        pending_ticks.push_back(mk(1'b1, 0, 0, -3142, -100, 1, 0));
        pending_ticks.push_back(mk(1'b1, 0, 0, 3142, -100, -1, 0));
        pending_ticks.push_back(mk(1'b1, 0, 0, 4095, 0, 100, 0));
        pending_ticks.push_back(mk(1'b1, 0, 0, -4096, 0, -100, 0));
        pending_ticks.push_back(mk(1'b1, 0, 0, 0, 1000, 0, 0));
        pending_ticks.push_back(mk(1'b1, 7, 7, 100, 7, 7, -4096));
        pending_ticks.push_back(mk(1'b0, 7, 7, 4095, 7, 7, -4096));
        pending_ticks.push_back(mk(1'b0, 7, 7, 3000, 7, 7, 3000));
        pending_ticks.push_back(mk(1'b0, 7, 7, 3000, 7, 7, 3000));
        pending_ticks.push_back(mk(1'b1, 0, 0, 0, 3, 4, 500));
        pending_ticks.push_back(mk(1'b1, 0, 0, 0, -3, -4, 500));
        drain();

        // Random phases over several register settings, extremes included.
        for (int p = 0; p < 8; p++) begin
            for (int r = 0; r < 8; r++) begin
                int v;
                case (p)
                    0: v = defaults[r];
                    1: v = maxes[r];
                    2: v = 0;
                    default: v = $urandom_range(0, maxes[r]);
                endcase
                if (r == wpsc_pkg::REG_DIST_TH && p >= 3) v = $urandom_range(0, 300);
                write_reg(3'(r), v);
            end
            if (p == 7) calm = 1'b1;
            while (pending_ticks.size() < 220) add_episode(p == 2 ? 0 : 200 * (p + 1));
            drain();
        end

        if (errors == 0) begin
            $display("waypoint_pi_steering_controller_unit verification clean");
        end else begin
            $display("waypoint_pi_steering_controller_unit verification failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("waypoint_pi_steering_controller_unit verification failed");
        $finish;
    end

endmodule
